[hdl/ewam_pkg.sv]
package ewam_pkg;

	localparam int DEF_WINDOW_DEPTH = 16;

	localparam int TEMP_W  = 12;
	localparam int HUM_W   = 10;
	localparam int AQ_W    = 9;
	localparam int HOLD_W  = 16;
	localparam int ACT_W   = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd30000;

	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AQ_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VALID    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd6;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [TEMP_W-1:0] temperature;
		logic [HUM_W-1:0]         humidity;
		logic [AQ_W-1:0]          air_quality;
		logic                     updates_suspended;
	} ewam_in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] report_temperature;
		logic [HUM_W-1:0]         report_humidity;
		logic [AQ_W-1:0]          report_air_quality;
		logic signed [TEMP_W-1:0] average_temperature;
		logic [HUM_W-1:0]         average_humidity;
		logic [AQ_W-1:0]          average_air_quality;
	} ewam_out_t;

endpackage

[hdl/ewam_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
module ewam_div #(
	parameter int DIV_W = 16,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   r1, m1, r2, m2;
	logic             ge1, ge2;
	logic [DEN_W-1:0] rem1;

	always_comb begin
		r1   = {rem_q, quo_q[DIV_W-1]};
		ge1  = r1 >= {1'b0, den_q};
		m1   = ge1 ? r1 - {1'b0, den_q} : r1;
		rem1 = m1[DEN_W-1:0];
		r2   = {rem1, quo_q[DIV_W-2]};
		ge2  = r2 >= {1'b0, den_q};
		m2   = ge2 ? r2 - {1'b0, den_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend bits out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
			rem_q <= m2[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/env_window_alarm_monitor.sv]
// Environment alarm monitor. A tick, an alarm-handled word, a suspended sample or an unknown
// action is handled without stalling the input. A sample is handled as a ring read, then a
// window and limit update when no report is due; with a report it adds three divisions of the
// window sums by the fill count on one shared divider that retires two quotient bits a cycle,
// DIV_W bits wide (the temperature sum width rounded up to even), then a load of the output
// register, which waits while an earlier report is still stalled. A finished report waits in
// an output register, so ticks and non-reporting samples keep flowing while it is stalled.
// The sample ring is a memory of WINDOW_DEPTH entries with registered read; it needs no
// clearing, since only entries written since the last alarm-handled word are ever read.
module env_window_alarm_monitor import ewam_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ewam_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ewam_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int TS_W   = TEMP_W + $clog2(WINDOW_DEPTH);
	localparam int HS_W   = HUM_W + $clog2(WINDOW_DEPTH);
	localparam int AS_W   = AQ_W + $clog2(WINDOW_DEPTH);
	localparam int DIV_W  = TS_W + (TS_W % 2);
	localparam int RING_W = TEMP_W + HUM_W + AQ_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPD    = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	localparam logic [1:0] SEL_TEMP = 2'd0;
	localparam logic [1:0] SEL_HUM  = 2'd1;
	localparam logic [1:0] SEL_AQ   = 2'd2;

	// configuration
	logic signed [TEMP_W-1:0] temp_lo_q, temp_hi_q;
	logic [HUM_W-1:0]         hum_lo_q, hum_hi_q;
	logic [AQ_W-1:0]          aq_limit_q;
	logic                     limits_valid_q;
	logic [HOLD_W-1:0]        hold_ticks_q;

	// window and alarm state
	logic [2:0]               state_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [FILL_W-1:0]        fill_q;
	logic signed [TS_W-1:0]   tsum_q;
	logic [HS_W-1:0]          hsum_q;
	logic [AS_W-1:0]          asum_q;
	logic                     alarm_q;
	logic [HOLD_W-1:0]        hold_q;
	logic [1:0]               sel_q;

	// payload
	ewam_in_t                 samp_q;
	logic [RING_W-1:0]        ring_mem [WINDOW_DEPTH];
	logic [RING_W-1:0]        rd_q;
	logic signed [TEMP_W-1:0] avg_t_q;
	logic [HUM_W-1:0]         avg_h_q;
	logic [AQ_W-1:0]          aq_avg_q;
	logic                     out_valid_q;
	ewam_out_t                out_q;

	logic                     in_acc;
	logic                     full;
	logic signed [TEMP_W-1:0] old_t;
	logic [HUM_W-1:0]         old_h;
	logic [AQ_W-1:0]          old_a;
	logic signed [TS_W-1:0]   tsum_nx;
	logic [HS_W-1:0]          hsum_nx;
	logic [AS_W-1:0]          asum_nx;
	logic                     abnormal;
	logic                     alarm_nx;
	logic [HOLD_W-1:0]        hold_dec;
	logic                     t_neg;
	logic [TS_W-1:0]          t_mag;
	logic [DIV_W-1:0]         div_num;
	logic                     div_start;
	logic                     div_done;
	logic [DIV_W-1:0]         div_quo;
	logic [DIV_W-1:0]         t_quo;
	logic                     out_load;

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_lo_q      <= '0;
			temp_hi_q      <= '0;
			hum_lo_q       <= '0;
			hum_hi_q       <= '0;
			aq_limit_q     <= '0;
			limits_valid_q <= 1'b0;
			hold_ticks_q   <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_LO:  temp_lo_q      <= cfg_data[TEMP_W-1:0];
				REG_TEMP_HI:  temp_hi_q      <= cfg_data[TEMP_W-1:0];
				REG_HUM_LO:   hum_lo_q       <= cfg_data[HUM_W-1:0];
				REG_HUM_HI:   hum_hi_q       <= cfg_data[HUM_W-1:0];
				REG_AQ_LIMIT: aq_limit_q     <= cfg_data[AQ_W-1:0];
				REG_VALID:    limits_valid_q <= cfg_data[0];
				REG_HOLD:     hold_ticks_q   <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ring: read the slot about to be overwritten every cycle, write during the update
	always_ff @(posedge clk) begin
		rd_q <= ring_mem[slot_q];
		if (state_q == ST_UPD) begin
			ring_mem[slot_q] <= {samp_q.temperature, samp_q.humidity, samp_q.air_quality};
		end
	end

	always_comb begin
		full  = fill_q == FILL_W'(WINDOW_DEPTH);
		old_t = rd_q[RING_W-1 -: TEMP_W];
		old_h = rd_q[AQ_W +: HUM_W];
		old_a = rd_q[AQ_W-1:0];
		tsum_nx = tsum_q + {{(TS_W-TEMP_W){samp_q.temperature[TEMP_W-1]}}, samp_q.temperature};
		hsum_nx = hsum_q + {{(HS_W-HUM_W){1'b0}}, samp_q.humidity};
		asum_nx = asum_q + {{(AS_W-AQ_W){1'b0}}, samp_q.air_quality};
		if (full) begin
			// drop the oldest sample from the sums
			tsum_nx = tsum_nx - {{(TS_W-TEMP_W){old_t[TEMP_W-1]}}, old_t};
			hsum_nx = hsum_nx - {{(HS_W-HUM_W){1'b0}}, old_h};
			asum_nx = asum_nx - {{(AS_W-AQ_W){1'b0}}, old_a};
		end
		abnormal = samp_q.temperature < temp_lo_q || samp_q.temperature > temp_hi_q
			|| samp_q.humidity < hum_lo_q || samp_q.humidity > hum_hi_q
			|| samp_q.air_quality > aq_limit_q;
		alarm_nx = alarm_q || (limits_valid_q && abnormal);
		hold_dec = (hold_q == '0) ? hold_q : hold_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
			tsum_q  <= '0;
			hsum_q  <= '0;
			asum_q  <= '0;
			alarm_q <= 1'b0;
			hold_q  <= '0;
			sel_q   <= SEL_TEMP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.action)
							ACT_SAMPLE: begin
								if (!in_data.updates_suspended) begin
									state_q <= ST_UPD;
								end
							end
							ACT_TICK: begin
								hold_q <= hold_dec;
								if (hold_dec == '0) begin
									alarm_q <= 1'b0;
								end
							end
							ACT_CLEAR: begin
								alarm_q <= 1'b0;
								hold_q  <= '0;
								slot_q  <= '0;
								fill_q  <= '0;
								tsum_q  <= '0;
								hsum_q  <= '0;
								asum_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_UPD: begin
					tsum_q <= tsum_nx;
					hsum_q <= hsum_nx;
					asum_q <= asum_nx;
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					if (limits_valid_q && abnormal) begin
						hold_q <= hold_ticks_q;
					end
					alarm_q <= alarm_nx;
					sel_q   <= SEL_TEMP;
					state_q <= (limits_valid_q && alarm_nx) ? ST_LAUNCH : ST_IDLE;
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (sel_q == SEL_AQ) begin
							state_q <= ST_OUT;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= in_data;
		end
	end

	// divide magnitudes; restore the temperature sign afterwards
	always_comb begin
		t_neg = tsum_q[TS_W-1];
		t_mag = t_neg ? TS_W'(-tsum_q) : TS_W'(tsum_q);
		case (sel_q)
			SEL_TEMP: div_num = DIV_W'(t_mag);
			SEL_HUM:  div_num = DIV_W'(hsum_q);
			default:  div_num = DIV_W'(asum_q);
		endcase
		t_quo = t_neg ? DIV_W'(-div_quo) : div_quo;
	end

	assign div_start = state_q == ST_LAUNCH;

	ewam_div #(
		.DIV_W (DIV_W),
		.DEN_W (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && div_done) begin
			case (sel_q)
				SEL_TEMP: avg_t_q <= t_quo[TEMP_W-1:0];
				SEL_HUM:  avg_h_q <= div_quo[HUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_load = state_q == ST_OUT && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// air quality mean is registered from the divider after the last step, like the other means
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.report_temperature  <= samp_q.temperature;
			out_q.report_humidity     <= samp_q.humidity;
			out_q.report_air_quality  <= samp_q.air_quality;
			out_q.average_temperature <= avg_t_q;
			out_q.average_humidity    <= avg_h_q;
			out_q.average_air_quality <= aq_avg_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && div_done && sel_q == SEL_AQ) begin
			aq_avg_q <= div_quo[AQ_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hdl/ewam_check.sv]
module ewam_check import ewam_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input ewam_in_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input ewam_out_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	logic in_acc;
	logic short_word;

	assign in_acc     = in_valid && !in_stall;
	assign short_word = in_data.action != ACT_SAMPLE || in_data.updates_suspended;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result word changed");

	a_short_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && short_word |=> !in_stall)
		else $error("tick, clear or skipped sample held the input");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !short_word |=> in_stall)
		else $error("sample accepted without window update cycle");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind env_window_alarm_monitor ewam_check u_ewam_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
